// File: sv/tmf_pkg.sv
// Shared types, constants and the sample conversion for the trimmed-mean filter.
`default_nettype none

package tmf_pkg;

   // Number of axes that keep their own statistics.
   localparam int unsigned AXES = 3;
   localparam int unsigned AXIS_IDX_W = (AXES > 1) ? $clog2(AXES) : 1;

   // Fixed field widths.
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned SAMPLE_W = 19;
   localparam int unsigned SUM_W    = 23;
   localparam int unsigned COUNT_W  = 4;

   // Conversion and window constants.
   localparam logic [BYTE_W-1:0]  SIGN_LIMIT = 8'd16;
   localparam logic [COUNT_W-1:0] WINDOW     = 4'd10;
   localparam int unsigned        KEPT_SHIFT = 3;

   typedef logic [KIND_W-1:0]           kind_type;
   typedef logic [BYTE_W-1:0]           byte_type;
   typedef logic signed [SAMPLE_W-1:0]  sample_type;
   typedef logic signed [SUM_W-1:0]     sum_type;
   typedef logic [COUNT_W-1:0]          count_type;
   typedef logic [AXIS_IDX_W-1:0]       axis_idx_type;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // Convert a raw byte pair to milli-g. Low weight 4 and high weight 1024
   // do not overlap, so the magnitude is a plain concatenation.
   function automatic sample_type to_milli_g(input byte_type lo, input byte_type hi);
      sample_type mag;
      if (hi > SIGN_LIMIT) begin
         mag = {1'b0, ~hi, ~lo, 2'b00};
         return -mag;
      end else begin
         return {1'b0, hi, lo, 2'b00};
      end
   endfunction

endpackage

`default_nettype wire

// File: sv/tmf_if.sv
// Valid/ready stream interfaces for the sample and result channels.
`default_nettype none

interface tmf_req_if;
   import tmf_pkg::*;
   logic     valid;
   logic     ready;
   kind_type kind;
   byte_type low_byte;
   byte_type high_byte;

   modport source (output valid, output kind, output low_byte, output high_byte,
                   input ready);
   modport sink   (input valid, input kind, input low_byte, input high_byte,
                   output ready);
endinterface

interface tmf_rsp_if;
   import tmf_pkg::*;
   logic       valid;
   logic       ready;
   kind_type   axis;
   sample_type mean_mg;

   modport source (output valid, output axis, output mean_mg, input ready);
   modport sink   (input valid, input axis, input mean_mg, output ready);
endinterface

`default_nettype wire

// File: sv/accel_trimmed_mean_filter.sv
// Top level of the per-axis trimmed-mean filter for accelerometer samples.
//
// The req channel carries one raw sample per beat: the axis tag (kind) and
// the sensor's low and high data bytes. Beats with an axis tag outside the
// configured axis range are accepted and dropped without touching state.
// Each sample is converted to milli-g as it enters the input register. Once
// it is held there and the result register can take a beat, the axis's
// count, sum, minimum and maximum are updated; on the tenth sample of an
// axis the sum less the extremes, divided by eight toward zero, is loaded
// into the rsp register and that axis starts over. Throughput is one sample
// per cycle while rsp can take a beat; the read-modify-write of the per-axis
// statistics lets samples of the same axis follow back to back.
// When the receiver holds rsp.ready low, the finished result stays in the
// rsp register while the input register still takes one more beat; req.ready
// falls only when both are full. A synchronous reset empties both registers
// and returns every axis to a zero count and sum with the extremes at their
// most positive and most negative values.
`default_nettype none

module accel_trimmed_mean_filter (
   input  wire logic clock,
   input  wire logic reset,
   tmf_req_if.sink   req,
   tmf_rsp_if.source rsp
);
   import tmf_pkg::*;

   // Input register: axis and converted sample.
   logic         in_valid_ff, in_valid_in;
   axis_idx_type in_axis_ff;
   sample_type   in_value_ff;

   // Result register.
   logic       out_valid_ff, out_valid_in;
   kind_type   out_axis_ff, out_axis_in;
   sample_type out_mean_ff, out_mean_in;

   // Per-axis statistics.
   count_type  count_ff [AXES];
   sum_type    sum_ff   [AXES];
   sample_type min_ff   [AXES];
   sample_type max_ff   [AXES];

   logic       advance;
   logic       req_take;
   logic       kind_ok;

   count_type  count_new;
   sum_type    sum_new;
   sample_type min_new;
   sample_type max_new;
   sum_type    trimmed;
   sum_type    biased;
   sum_type    shifted;
   logic       window_done;

   // The input stage moves on whenever the result register can take a beat.
   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = !in_valid_ff || advance;
   assign req_take  = req.valid && req.ready;
   assign kind_ok   = ({{(32-KIND_W){1'b0}}, req.kind} < AXES);

   always_comb begin
      if (req.ready) begin
         in_valid_in = req_take && kind_ok;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Payload of the input register is loaded on every accepted beat.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_axis_ff  <= req.kind[AXIS_IDX_W-1:0];
         in_value_ff <= to_milli_g(req.low_byte, req.high_byte);
      end
   end

   // Read-modify-write of the selected axis's statistics.
   always_comb begin
      count_new   = count_ff[in_axis_ff] + count_type'(1);
      sum_new     = sum_ff[in_axis_ff] + SUM_W'(in_value_ff);
      min_new     = (in_value_ff < min_ff[in_axis_ff]) ? in_value_ff : min_ff[in_axis_ff];
      max_new     = (in_value_ff > max_ff[in_axis_ff]) ? in_value_ff : max_ff[in_axis_ff];
      window_done = (count_new == WINDOW);
      trimmed     = sum_new - SUM_W'(min_new) - SUM_W'(max_new);
      // Round toward zero: bias negative values before the arithmetic shift.
      biased      = trimmed + (trimmed[SUM_W-1] ? sum_type'((1 << KEPT_SHIFT) - 1)
                                                : sum_type'(0));
      shifted     = biased >>> KEPT_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            count_ff[a] <= '0;
            sum_ff[a]   <= '0;
            min_ff[a]   <= SAMPLE_MAX;
            max_ff[a]   <= SAMPLE_MIN;
         end
      end else if (in_valid_ff && advance) begin
         if (window_done) begin
            count_ff[in_axis_ff] <= '0;
            sum_ff[in_axis_ff]   <= '0;
            min_ff[in_axis_ff]   <= SAMPLE_MAX;
            max_ff[in_axis_ff]   <= SAMPLE_MIN;
         end else begin
            count_ff[in_axis_ff] <= count_new;
            sum_ff[in_axis_ff]   <= sum_new;
            min_ff[in_axis_ff]   <= min_new;
            max_ff[in_axis_ff]   <= max_new;
         end
      end
   end

   // Result register: loaded when a window closes, emptied when taken.
   always_comb begin
      out_valid_in = out_valid_ff && !rsp.ready;
      out_axis_in  = out_axis_ff;
      out_mean_in  = out_mean_ff;
      if (in_valid_ff && advance && window_done) begin
         out_valid_in = 1'b1;
         out_axis_in  = KIND_W'(in_axis_ff);
         out_mean_in  = shifted[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_axis_ff <= out_axis_in;
      out_mean_ff <= out_mean_in;
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.axis    = out_axis_ff;
   assign rsp.mean_mg = out_mean_ff;

endmodule

`default_nettype wire

// File: tb/accel_trimmed_mean_filter_test.sv
// Self-checking testbench for the per-axis accelerometer trimmed-mean filter.
`timescale 1ns / 1ps

module accel_trimmed_mean_filter_test;
   import tmf_pkg::*;

   // Axis tags used by the directed beats; AXIS_NONE lies past the last axis.
   localparam kind_type AXIS_X    = 2'd0;
   localparam kind_type AXIS_Y    = 2'd1;
   localparam kind_type AXIS_Z    = 2'd2;
   localparam kind_type AXIS_NONE = 2'd3;

   // Conversion weights and the number of samples kept after trimming.
   localparam int       LOW_WEIGHT  = 4;
   localparam int       HIGH_WEIGHT = 1024;
   localparam int       KEPT_COUNT  = 8;
   localparam byte_type BYTE_FULL   = 8'hFF;

   localparam int RANDOM_SAMPLES = 2000;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int PRINT_LIMIT    = 40;

   typedef struct packed {
      kind_type   axis;
      sample_type mean_mg;
   } mean_beat_type;

   // Predicts the mean of each axis window and checks the result beats.
   class trimmed_mean_board;
      count_type     window_fill [AXES];
      sum_type       window_sum  [AXES];
      sample_type    window_low  [AXES];
      sample_type    window_high [AXES];
      mean_beat_type pending_means [$];
      int            errors;

      function new();
         errors = 0;
         for (int a = 0; a < AXES; a++) begin
            clear_window(a);
         end
      endfunction

      function void clear_window(int a);
         window_fill[a] = '0;
         window_sum[a]  = '0;
         window_low[a]  = SAMPLE_MAX;
         window_high[a] = SAMPLE_MIN;
      endfunction

      function sample_type convert_sample(byte_type lo, byte_type hi);
         int mag;
         if (hi > SIGN_LIMIT) begin
            // Negative readings are stored inverted from all ones.
            mag = int'(BYTE_FULL - lo) * LOW_WEIGHT + int'(BYTE_FULL - hi) * HIGH_WEIGHT;
            return sample_type'(-mag);
         end
         return sample_type'(int'(lo) * LOW_WEIGHT + int'(hi) * HIGH_WEIGHT);
      endfunction

      // Notes one accepted sample beat and queues a mean when a window closes.
      function void note_sample(kind_type k, byte_type lo, byte_type hi);
         sample_type    v;
         int            trimmed;
         mean_beat_type beat;
         if (k >= AXES) return;
         v = convert_sample(lo, hi);
         window_sum[k] = window_sum[k] + v;
         if (v < window_low[k]) window_low[k] = v;
         if (v > window_high[k]) window_high[k] = v;
         window_fill[k] = window_fill[k] + 1'b1;
         if (window_fill[k] < WINDOW) return;
         trimmed = int'(window_sum[k]) - int'(window_low[k]) - int'(window_high[k]);
         beat.axis    = k;
         beat.mean_mg = sample_type'(trimmed / KEPT_COUNT);
         pending_means.push_back(beat);
         clear_window(k);
      endfunction

      function void report_mismatch(string what);
         errors++;
         if (errors <= PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, what);
      endfunction

      // Compares one accepted result beat with the oldest predicted mean.
      function void check_result(kind_type axis, sample_type mean_mg);
         mean_beat_type want;
         if (pending_means.size() == 0) begin
            report_mismatch($sformatf("unexpected result axis %0d mean %0d", axis, mean_mg));
            return;
         end
         want = pending_means.pop_front();
         if (axis !== want.axis) begin
            report_mismatch($sformatf("axis %0d, expected %0d", axis, want.axis));
         end
         if (mean_mg !== want.mean_mg) begin
            report_mismatch($sformatf("axis %0d mean %0d, expected %0d",
                                      want.axis, mean_mg, want.mean_mg));
         end
      endfunction

      function int pending();
         return pending_means.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic sink_ready = 1'b0;
   int   cycle_count = 0;

   int   ready_phase_left = 0;
   int   ready_mode = 0;
   int   ready_tick = 0;

   trimmed_mean_board board = new();

   // Directed window for the X axis: every conversion corner once.
   byte_type directed_lo [10] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255,
                                  8'd0, 8'd128, 8'd1, 8'd254, 8'd127};
   byte_type directed_hi [10] = '{8'd0, 8'd16, 8'd17, 8'd255, 8'd17,
                                  8'd16, 8'd200, 8'd1, 8'd254, 8'd128};

   tmf_req_if req_ch ();
   tmf_rsp_if rsp_ch ();

   accel_trimmed_mean_filter DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   assign rsp_ch.ready = sink_ready;

   always #5 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Result beats are checked at the rising edge they are accepted.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         board.check_result(rsp_ch.axis, rsp_ch.mean_mg);
      end
   end

   // The receiver moves through phases: always ready, mostly ready,
   // mostly stalled, and ready only when the tick count is a multiple of five.
   always @(negedge clock) begin
      ready_tick <= ready_tick + 1;
      if (ready_phase_left == 0) begin
         ready_mode       <= $urandom_range(0, 3);
         ready_phase_left <= $urandom_range(10, 150);
      end else begin
         ready_phase_left <= ready_phase_left - 1;
      end
      case (ready_mode)
         0: begin
            sink_ready <= 1'b1;
         end
         1: begin
            sink_ready <= ($urandom_range(0, 3) != 0);
         end
         2: begin
            sink_ready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            sink_ready <= (ready_tick % 5 == 0);
         end
      endcase
   end

   // Presents one sample beat from a falling edge until it is accepted,
   // then returns at the next falling edge.
   task automatic send_sample(kind_type k, byte_type lo, byte_type hi);
      req_ch.valid     <= 1'b1;
      req_ch.kind      <= k;
      req_ch.low_byte  <= lo;
      req_ch.high_byte <= hi;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      board.note_sample(k, lo, hi);
      @(negedge clock);
   endtask

   // Random raw bytes weighted toward the sign boundary and the extremes.
   task automatic pick_bytes(output byte_type lo, output byte_type hi);
      int mode;
      mode = $urandom_range(0, 9);
      lo   = byte_type'($urandom_range(0, 255));
      case (mode)
         0, 1, 2, 3: begin
            hi = byte_type'($urandom_range(0, 255));
         end
         4, 5: begin
            hi = byte_type'($urandom_range(0, SIGN_LIMIT));
         end
         6: begin
            hi = byte_type'($urandom_range(SIGN_LIMIT - 1, SIGN_LIMIT + 2));
         end
         7: begin
            // Largest positive, most negative, and both kinds of zero.
            case ($urandom_range(0, 3))
               0: begin lo = 8'd255; hi = SIGN_LIMIT; end
               1: begin lo = 8'd0;   hi = SIGN_LIMIT + 1'b1; end
               2: begin lo = 8'd255; hi = 8'd255; end
               default: begin lo = 8'd0; hi = 8'd0; end
            endcase
         end
         default: begin
            hi = byte_type'($urandom_range(SIGN_LIMIT + 1, 255));
         end
      endcase
   endtask

   initial begin
      int       sent;
      int       burst;
      int       gap;
      bit       drained;
      kind_type k;
      byte_type lo;
      byte_type hi;

      req_ch.valid     = 1'b0;
      req_ch.kind      = '0;
      req_ch.low_byte  = '0;
      req_ch.high_byte = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: one X window over every conversion corner, with
      // beats for the missing axis mixed in, then a Y window of the most
      // negative reading for the lowest possible mean.
      for (int i = 0; i < 10; i++) begin
         send_sample(AXIS_X, directed_lo[i], directed_hi[i]);
         if (i == 3) send_sample(AXIS_NONE, 8'd255, 8'd255);
         if (i == 7) send_sample(AXIS_NONE, 8'd0, 8'd0);
      end
      for (int i = 0; i < 10; i++) begin
         send_sample(AXIS_Y, 8'd0, SIGN_LIMIT + 1'b1);
      end
      send_sample(AXIS_Z, 8'd255, SIGN_LIMIT);

      // Random part in bursts; halfway through the sender waits for every
      // pending mean to drain.
      sent    = 0;
      drained = 1'b0;
      while (sent < RANDOM_SAMPLES) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(1, 16);
         for (int i = 0; i < burst && sent < RANDOM_SAMPLES; i++) begin
            k = ($urandom_range(0, 11) == 0) ? AXIS_NONE : kind_type'($urandom_range(0, 2));
            pick_bytes(lo, hi);
            send_sample(k, lo, hi);
            if (k < AXES) sent++;
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         if (!drained && sent >= RANDOM_SAMPLES / 2) begin
            req_ch.valid <= 1'b0;
            while (board.pending() != 0) @(negedge clock);
            drained = 1'b1;
            @(negedge clock);
         end
      end
      req_ch.valid <= 1'b0;

      // Wait for the last means, then keep the clock running for any stray beat.
      while (board.pending() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (board.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
